// ===== src/cfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants of the CRC-checked frame receiver: verdict
// codes, register indexes, CRC-32/BZIP2 constants and state encodings.
// ----------------------------------------------------------------------------
package cfr_pkg;

  // Default number of payload bytes in one frame.
  localparam int PAYLOAD_BYTES_DEF = 11;

  // Field widths fixed by the frame format.
  localparam int BYTE_W   = 8;
  localparam int POS_W    = 6;
  localparam int CRC_W    = 32;
  localparam int CFG_IDX_W = 2;

  // CRC-32/BZIP2: MSB first, init all ones, final XOR all ones.
  localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFF_FFFF;

  // Reset values of the configuration registers.
  localparam logic [BYTE_W-1:0] RTX_CODE_RST = 8'd21;
  localparam logic [BYTE_W-1:0] ACK_CODE_RST = 8'd6;
  localparam logic [BYTE_W-1:0] PAD_BYTE_RST = 8'd255;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RTX_CODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_BYTE = 2'd2;

  // Verdict codes reported with each result.
  localparam logic [1:0] VERDICT_CRC_BAD  = 2'd0;
  localparam logic [1:0] VERDICT_RESEND   = 2'd1;
  localparam logic [1:0] VERDICT_ACK_DROP = 2'd2;
  localparam logic [1:0] VERDICT_DATA     = 2'd3;

  // Position of the receiver within a frame.
  typedef enum logic [1:0] {
    PH_LEN     = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CRC     = 2'd2
  } phase_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CRC,
    ST_SWEEP,
    ST_DRAIN,
    ST_JUDGE,
    ST_SINGLE,
    ST_READ,
    ST_LOAD
  } fsm_t;

  // Control from the sequencer to the bit-serial CRC unit.
  typedef struct packed {
    logic start;  // load a new byte and begin shifting
    logic init;   // restart the CRC from all ones (length byte)
  } crc_ctrl_t;

endpackage : cfr_pkg
`default_nettype wire

// ===== src/cfr_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_in_if
// Valid/ready channel that carries received bytes into the frame receiver.
// ----------------------------------------------------------------------------
interface cfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface : cfr_in_if
`default_nettype wire

// ===== src/cfr_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_out_if
// Valid/ready channel that carries frame verdicts and payload bytes out.
// ----------------------------------------------------------------------------
interface cfr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic [7:0] frame_len;
  logic [7:0] payload_byte;
  logic [5:0] payload_pos;
  logic       last;

  modport source (output valid, output verdict, output frame_len, output payload_byte,
                  output payload_pos, output last, input ready);
  modport sink   (input valid, input verdict, input frame_len, input payload_byte,
                  input payload_pos, input last, output ready);
endinterface : cfr_out_if
`default_nettype wire

// ===== src/cfr_crc_serial.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_crc_serial
// Bit-serial CRC-32/BZIP2 unit: folds one byte into the running CRC, one
// bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module cfr_crc_serial
  import cfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire crc_ctrl_t         ctrl,
  input  wire logic [BYTE_W-1:0] data_in,
  output logic [CRC_W-1:0]       crc,
  output logic                   busy
);

  logic [CRC_W-1:0]  crc_r,     crc_nxt;
  logic [BYTE_W-1:0] shift_r,   shift_nxt;
  logic [2:0]        bit_cnt_r, bit_cnt_nxt;
  logic              busy_r,    busy_nxt;
  logic              fb;

  // The data bit meets the CRC MSB; the result selects the polynomial.
  assign fb = crc_r[CRC_W-1] ^ shift_r[BYTE_W-1];

  always_comb begin
    crc_nxt     = crc_r;
    shift_nxt   = shift_r;
    bit_cnt_nxt = bit_cnt_r;
    busy_nxt    = busy_r;
    if (ctrl.start) begin
      shift_nxt   = data_in;
      bit_cnt_nxt = 3'd0;
      busy_nxt    = 1'b1;
      if (ctrl.init) begin
        crc_nxt = CRC_ONES;
      end
    end else if (busy_r) begin
      crc_nxt     = {crc_r[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
      shift_nxt   = {shift_r[BYTE_W-2:0], 1'b0};
      bit_cnt_nxt = bit_cnt_r + 3'd1;
      if (bit_cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r     <= CRC_ONES;
      bit_cnt_r <= 3'd0;
      busy_r    <= 1'b0;
    end else begin
      crc_r     <= crc_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      busy_r    <= busy_nxt;
    end
    shift_r <= shift_nxt;
  end

  assign crc  = crc_r;
  assign busy = busy_r;

endmodule : cfr_crc_serial
`default_nettype wire

// ===== src/crc_checked_frame_receiver.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc_checked_frame_receiver
// Frames received bytes into fixed-length frames, checks their CRC-32/BZIP2
// and reports a verdict or the accepted payload bytes.
// ----------------------------------------------------------------------------
// Usage: bytes enter one request at a time on the in_ch channel. A frame is
// one length byte, PAYLOAD_BYTES payload bytes and four CRC bytes, least
// significant first. Every length or payload byte is folded into the CRC by a
// bit-serial unit, so such a byte holds the input through its accept, the
// shifting of its eight bits and the return to idle; a CRC byte skips the unit.
// After the fourth CRC byte the payload memory is swept once to test for a
// control frame and the verdict is judged; then results go out on out_ch:
// one request for a bad CRC, a resend or an ack frame, or PAYLOAD_BYTES
// requests for a data frame, each one a memory read and then a load.
// An output register sits in front of out_ch; once the last result of a
// frame is loaded there, the next byte is accepted even while that result
// waits. If the receiver stalls, the sequencer holds until the register
// frees up, and in_ch stays not ready meanwhile.
// Reset (synchronous, rst_n low) returns to awaiting a length byte, restores
// the register defaults and drops any pending result. The cfg port writes a
// register at any edge with cfg_we high; it is meant to be used while idle.
// ----------------------------------------------------------------------------
module crc_checked_frame_receiver
  import cfr_pkg::*;
#(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  cfr_in_if.sink                    in_ch,
  cfr_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [BYTE_W-1:0]    cfg_wdata
);

  // Index width for the payload memory; also wide enough for the CRC byte
  // count, since PAYLOAD_BYTES is at least three.
  localparam int IDX_W = $clog2(PAYLOAD_BYTES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PAYLOAD_BYTES - 1);
  localparam logic [IDX_W-1:0] CRC_LAST = IDX_W'(3);

  // Configuration registers.
  logic [BYTE_W-1:0] rtx_code_r;
  logic [BYTE_W-1:0] ack_code_r;
  logic [BYTE_W-1:0] pad_byte_r;

  // Frame state.
  fsm_t              state_r, state_nxt;
  phase_t            phase_r;
  logic [IDX_W-1:0]  cnt_r;
  logic [IDX_W-1:0]  idx_r;
  logic [CRC_W-1:0]  rcrc_r;
  logic [BYTE_W-1:0] len_r;
  logic [1:0]        verdict_r;

  // Control frame test, built up during the sweep.
  logic              chk_v_r;
  logic              chk_first_r;
  logic              rtx_hit_r;
  logic              ack_hit_r;
  logic              pad_ok_r;

  // Payload memory with a registered read port.
  logic [BYTE_W-1:0] pay_mem [PAYLOAD_BYTES];
  logic [BYTE_W-1:0] rd_data_r;
  logic              mem_we;
  logic              mem_re;

  // Output register.
  logic              out_valid_r;
  logic [1:0]        out_verdict_r;
  logic [BYTE_W-1:0] out_len_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [POS_W-1:0]  out_pos_r;
  logic              out_last_r;
  logic              out_free;
  logic              out_load_single;
  logic              out_load_data;

  // CRC unit.
  crc_ctrl_t         crc_ctrl;
  logic [CRC_W-1:0]  crc_val;
  logic              crc_busy;

  logic              in_acc;
  logic              frame_done;
  logic              crc_ok;
  logic              ctl_len;
  logic [1:0]        verdict_sel;

  cfr_crc_serial u_crc (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (crc_ctrl),
    .data_in (in_ch.rx_byte),
    .crc     (crc_val),
    .busy    (crc_busy)
  );

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign frame_done = in_acc && (phase_r == PH_CRC) && (cnt_r == CRC_LAST);
  assign out_free   = !out_valid_r || out_ch.ready;

  // Verdict priority: CRC mismatch, then retransmit, then ack, else data.
  assign crc_ok  = (rcrc_r == ~crc_val);
  assign ctl_len = (len_r == BYTE_W'(1)) && pad_ok_r;

  always_comb begin
    if (!crc_ok) begin
      verdict_sel = VERDICT_CRC_BAD;
    end else if (ctl_len && rtx_hit_r) begin
      verdict_sel = VERDICT_RESEND;
    end else if (ctl_len && ack_hit_r) begin
      verdict_sel = VERDICT_ACK_DROP;
    end else begin
      verdict_sel = VERDICT_DATA;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (phase_r)
            PH_CRC:  state_nxt = frame_done ? ST_SWEEP : ST_IDLE;
            default: state_nxt = ST_CRC;
          endcase
        end
      end
      ST_CRC: begin
        if (!crc_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        if (idx_r == IDX_LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_nxt = ST_JUDGE;
      ST_JUDGE:  state_nxt = (verdict_sel == VERDICT_DATA) ? ST_READ : ST_SINGLE;
      ST_SINGLE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ:   state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (out_free) begin
          state_nxt = (idx_r == IDX_LAST) ? ST_IDLE : ST_READ;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs. Ready is high throughout idle, so a valid request
  // there is an accepted one.
  always_comb begin
    in_ch.ready     = 1'b0;
    crc_ctrl        = '0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    out_load_single = 1'b0;
    out_load_data   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          case (phase_r)
            PH_PAYLOAD: begin
              crc_ctrl.start = 1'b1;
              mem_we         = 1'b1;
            end
            PH_CRC: begin
            end
            default: begin
              crc_ctrl.start = 1'b1;
              crc_ctrl.init  = 1'b1;
            end
          endcase
        end
      end
      ST_SWEEP:  mem_re          = 1'b1;
      ST_READ:   mem_re          = 1'b1;
      ST_SINGLE: out_load_single = out_free;
      ST_LOAD:   out_load_data   = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rtx_code_r <= RTX_CODE_RST;
      ack_code_r <= ACK_CODE_RST;
      pad_byte_r <= PAD_BYTE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_RTX_CODE: rtx_code_r <= cfg_wdata;
        CFG_ACK_CODE: ack_code_r <= cfg_wdata;
        CFG_PAD_BYTE: pad_byte_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Frame bookkeeping: phase, byte count, length and received CRC.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN;
      cnt_r   <= '0;
      rcrc_r  <= '0;
      len_r   <= '0;
    end else if (in_acc) begin
      case (phase_r)
        PH_PAYLOAD: begin
          if (cnt_r == IDX_LAST) begin
            cnt_r   <= '0;
            phase_r <= PH_CRC;
          end else begin
            cnt_r <= cnt_r + IDX_W'(1);
          end
        end
        PH_CRC: begin
          // CRC bytes arrive least significant first.
          rcrc_r <= {in_ch.rx_byte, rcrc_r[CRC_W-1:BYTE_W]};
          if (cnt_r == CRC_LAST) begin
            cnt_r   <= '0;
            phase_r <= PH_LEN;
          end else begin
            cnt_r <= cnt_r + IDX_W'(1);
          end
        end
        default: begin
          len_r   <= in_ch.rx_byte;
          rcrc_r  <= '0;
          cnt_r   <= '0;
          phase_r <= PH_PAYLOAD;
        end
      endcase
    end
  end

  // Sweep and emit index, sweep pipeline, verdict and control-frame flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_v_r <= 1'b0;
    end else begin
      chk_v_r <= (state_r == ST_SWEEP);
    end
    chk_first_r <= (idx_r == '0);
    if (frame_done || state_r == ST_JUDGE) begin
      idx_r <= '0;
    end else if ((state_r == ST_SWEEP || out_load_data) && idx_r != IDX_LAST) begin
      idx_r <= idx_r + IDX_W'(1);
    end
    if (state_r == ST_JUDGE) begin
      verdict_r <= verdict_sel;
    end
    if (frame_done) begin
      pad_ok_r <= 1'b1;
    end else if (chk_v_r && !chk_first_r) begin
      pad_ok_r <= pad_ok_r && (rd_data_r == pad_byte_r);
    end
    if (chk_v_r && chk_first_r) begin
      rtx_hit_r <= (rd_data_r == rtx_code_r);
      ack_hit_r <= (rd_data_r == ack_code_r);
    end
  end

  // Payload memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pay_mem[cnt_r] <= in_ch.rx_byte;
    end
    if (mem_re) begin
      rd_data_r <= pay_mem[idx_r];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load_single || out_load_data) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load_single) begin
      out_verdict_r <= verdict_r;
      out_len_r     <= len_r;
      out_byte_r    <= '0;
      out_pos_r     <= '0;
      out_last_r    <= 1'b1;
    end else if (out_load_data) begin
      out_verdict_r <= VERDICT_DATA;
      out_len_r     <= len_r;
      out_byte_r    <= rd_data_r;
      out_pos_r     <= POS_W'(idx_r);
      out_last_r    <= (idx_r == IDX_LAST);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.verdict      = out_verdict_r;
  assign out_ch.frame_len    = out_len_r;
  assign out_ch.payload_byte = out_byte_r;
  assign out_ch.payload_pos  = out_pos_r;
  assign out_ch.last         = out_last_r;

`ifndef SYNTHESIS
  // A new byte is never taken while the CRC unit is still shifting.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !crc_busy)
    else $error("input ready while CRC unit busy");

  // Every non-data verdict is a single, final result with no payload.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.verdict != VERDICT_DATA) |->
      (out_ch.last && out_ch.payload_byte == '0 && out_ch.payload_pos == '0))
    else $error("non-data verdict not a single final result");

  // Data results never point beyond the payload, and last marks the final one.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.verdict == VERDICT_DATA) |->
      (out_ch.payload_pos <= POS_W'(PAYLOAD_BYTES - 1) &&
       out_ch.last == (out_ch.payload_pos == POS_W'(PAYLOAD_BYTES - 1))))
    else $error("payload position or last flag wrong");

  // Loading a result only happens into a free output register.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load_single || out_load_data) |-> out_free)
    else $error("result loaded over a pending result");
`endif

endmodule : crc_checked_frame_receiver
`default_nettype wire

// ===== sim/cfr_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_frame_checker
// Watches both channels and the register port of the frame receiver, keeps
// its own model of the framing, the CRC and the verdict logic, and compares
// every result request with the oldest expected one.
// ----------------------------------------------------------------------------
module cfr_frame_checker
  import cfr_pkg::*;
#(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  cfr_in_if                    in_ch,
  cfr_out_if                   out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  output int unsigned          pending_results,
  output int unsigned          mismatch_count
);

  typedef struct packed {
    logic [1:0]        verdict;
    logic [BYTE_W-1:0] frame_len;
    logic [BYTE_W-1:0] payload_byte;
    logic [POS_W-1:0]  payload_pos;
    logic              last;
  } frame_result_t;

  // Register copies.
  logic [BYTE_W-1:0] rtx_code;
  logic [BYTE_W-1:0] ack_code;
  logic [BYTE_W-1:0] pad_value;

  // Framing state.
  phase_t            rx_phase;
  logic [POS_W-1:0]  byte_cnt;
  logic [CRC_W-1:0]  crc_run;
  logic [CRC_W-1:0]  crc_rx;
  logic [BYTE_W-1:0] len_byte;
  logic [BYTE_W-1:0] payload_mem [PAYLOAD_BYTES];

  frame_result_t expected_q[$];
  int unsigned   errors = 0;

  function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 24'd0};
    for (int k = 0; k < 8; k++) begin
      c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // Length one, the code first and pad bytes in every other position.
  function automatic bit is_control(input logic [BYTE_W-1:0] code);
    bit hit;
    hit = (len_byte == 8'd1) && (payload_mem[0] == code);
    for (int i = 1; i < PAYLOAD_BYTES; i++) begin
      if (payload_mem[i] != pad_value) hit = 1'b0;
    end
    return hit;
  endfunction

  task automatic push_result(input logic [1:0] v, input logic [BYTE_W-1:0] b,
                             input logic [POS_W-1:0] pos, input logic last);
    frame_result_t r;
    r.verdict      = v;
    r.frame_len    = len_byte;
    r.payload_byte = b;
    r.payload_pos  = pos;
    r.last         = last;
    expected_q.push_back(r);
  endtask

  task automatic judge_frame();
    if (crc_rx != ~crc_run) begin
      push_result(VERDICT_CRC_BAD, 8'd0, 6'd0, 1'b1);
    end else if (is_control(rtx_code)) begin
      push_result(VERDICT_RESEND, 8'd0, 6'd0, 1'b1);
    end else if (is_control(ack_code)) begin
      push_result(VERDICT_ACK_DROP, 8'd0, 6'd0, 1'b1);
    end else begin
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
        push_result(VERDICT_DATA, payload_mem[i], POS_W'(i), i == PAYLOAD_BYTES - 1);
      end
    end
  endtask

  task automatic predict_byte(input logic [BYTE_W-1:0] b);
    case (rx_phase)
      PH_PAYLOAD: begin
        if (byte_cnt < PAYLOAD_BYTES) payload_mem[byte_cnt] = b;
        crc_run  = crc_fold(crc_run, b);
        byte_cnt = byte_cnt + 1'b1;
        if (byte_cnt >= PAYLOAD_BYTES) begin
          byte_cnt = '0;
          rx_phase = PH_CRC;
        end
      end
      PH_CRC: begin
        // CRC bytes arrive least significant first.
        crc_rx   = crc_rx | ({24'd0, b} << (8 * byte_cnt[1:0]));
        byte_cnt = byte_cnt + 1'b1;
        if (byte_cnt >= 4) begin
          judge_frame();
          byte_cnt = '0;
          crc_rx   = '0;
          rx_phase = PH_LEN;
        end
      end
      default: begin
        len_byte = b;
        crc_run  = crc_fold(CRC_ONES, b);
        crc_rx   = '0;
        byte_cnt = '0;
        rx_phase = PH_PAYLOAD;
      end
    endcase
  endtask

  task automatic report_field(input string name, input logic [BYTE_W-1:0] want,
                              input logic [BYTE_W-1:0] got);
    $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
    errors++;
  endtask

  always @(posedge clk) begin : monitor
    frame_result_t got;
    frame_result_t want;
    if (!rst_n) begin
      rtx_code  = RTX_CODE_RST;
      ack_code  = ACK_CODE_RST;
      pad_value = PAD_BYTE_RST;
      rx_phase  = PH_LEN;
      byte_cnt  = '0;
      crc_run   = CRC_ONES;
      crc_rx    = '0;
      len_byte  = '0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_RTX_CODE: rtx_code  = cfg_wdata;
          CFG_ACK_CODE: ack_code  = cfg_wdata;
          CFG_PAD_BYTE: pad_value = cfg_wdata;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.verdict, out_ch.frame_len, out_ch.payload_byte,
               out_ch.payload_pos, out_ch.last};
        if (expected_q.size() == 0) begin
          $display({"%0t: unexpected result: expected none, got verdict %0d",
                    " len 0x%0h byte 0x%0h pos %0d last %0d"},
                   $time, got.verdict, got.frame_len, got.payload_byte,
                   got.payload_pos, got.last);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.verdict !== want.verdict)
            report_field("verdict", want.verdict, got.verdict);
          if (got.frame_len !== want.frame_len)
            report_field("frame_len", want.frame_len, got.frame_len);
          if (got.payload_byte !== want.payload_byte)
            report_field("payload_byte", want.payload_byte, got.payload_byte);
          if (got.payload_pos !== want.payload_pos)
            report_field("payload_pos", want.payload_pos, got.payload_pos);
          if (got.last !== want.last)
            report_field("last", want.last, got.last);
        end
      end
      if (in_ch.valid && in_ch.ready) predict_byte(in_ch.rx_byte);
    end
    pending_results <= expected_q.size();
    mismatch_count  <= errors;
  end

endmodule : cfr_frame_checker

// ===== sim/tb_crc_checked_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crc_checked_frame_receiver
// Drives framed byte streams into the receiver and gives the verdict. Frames
// are built with a correct or a deliberately broken CRC, as data frames,
// resend and ack control frames, near misses of the control pattern and raw
// noise. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_crc_checked_frame_receiver;
  import cfr_pkg::*;

  localparam int PL            = PAYLOAD_BYTES_DEF;
  localparam int FRAME_BYTES   = PL + 5;
  localparam int MAX_GAP       = 14;
  // One long receiver hold-off, long enough for the block to back up all
  // the way to its input.
  localparam int LONG_HOLD     = 400;
  // Cycles to let pass once nothing is expected, before a register write or
  // the verdict.
  localparam int SETTLE_CYCLES = 24;
  // Cycles without any accepted request before the run is declared hung.
  // The slowest legal quiet stretch is the long hold-off; this is several
  // times that.
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASES        = 3;
  localparam int FRAMES_PER_PH = 2;

  typedef enum logic [2:0] {
    FR_DATA,
    FR_RESEND,
    FR_ACK,
    FR_NEAR_CONTROL,
    FR_BAD_CRC,
    FR_NOISE
  } frame_kind_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [BYTE_W-1:0]    cfg_wdata;
  int unsigned          pending_results;
  int unsigned          mismatch_count;

  // Idle control shared by the sender and the receiver.
  bit                   in_no_idle  = 1'b0;
  bit                   out_no_idle = 1'b0;
  int unsigned          holds_asked = 0;
  int unsigned          holds_done  = 0;

  // Register values as last written, used to build control frames.
  logic [BYTE_W-1:0]    rtx_now = RTX_CODE_RST;
  logic [BYTE_W-1:0]    ack_now = ACK_CODE_RST;
  logic [BYTE_W-1:0]    pad_now = PAD_BYTE_RST;

  // Payload of the frame being assembled.
  logic [BYTE_W-1:0]    frame_pl [PL];

  cfr_in_if  in_ch ();
  cfr_out_if out_ch ();

  crc_checked_frame_receiver #(
    .PAYLOAD_BYTES(PL)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  cfr_frame_checker #(
    .PAYLOAD_BYTES(PL)
  ) i_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .pending_results(pending_results),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Number of idle cycles before the next request on one side.
  function automatic int unsigned draw_gap(input bit no_idle);
    return no_idle ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // CRC-32/BZIP2 over the length byte and the current payload, used only to
  // build well-formed frames.
  function automatic logic [CRC_W-1:0] frame_crc(input logic [BYTE_W-1:0] len);
    logic [CRC_W-1:0]  c;
    logic [BYTE_W-1:0] b;
    c = CRC_ONES;
    for (int i = 0; i <= PL; i++) begin
      if (i == 0) b = len;
      else b = frame_pl[i-1];
      c ^= {b, 24'd0};
      for (int k = 0; k < 8; k++) begin
        c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
    end
    return ~c;
  endfunction

  // Offers one byte and returns at the edge where it is accepted. Valid is
  // only lowered when a gap is drawn, so back-to-back requests keep it high.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = draw_gap(in_no_idle);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Sends the length byte, the payload and the CRC least significant byte
  // first. A nonzero flip mask breaks the CRC on purpose.
  task automatic send_frame(input logic [BYTE_W-1:0] len, input logic [CRC_W-1:0] flip);
    logic [CRC_W-1:0] crc;
    crc = frame_crc(len) ^ flip;
    send_byte(len);
    for (int i = 0; i < PL; i++) send_byte(frame_pl[i]);
    for (int k = 0; k < 4; k++) send_byte(crc[8*k +: 8]);
  endtask

  task automatic fill_control(input logic [BYTE_W-1:0] code);
    frame_pl[0] = code;
    for (int i = 1; i < PL; i++) frame_pl[i] = pad_now;
  endtask

  task automatic fill_random();
    for (int i = 0; i < PL; i++) frame_pl[i] = 8'($urandom);
  endtask

  // Stops offering, waits until every predicted result has been accepted
  // and then lets the block settle. The first edge makes sure the count
  // already includes the results of the last accepted byte.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges; write enable stays high
  // across them and drops once at the end.
  task automatic write_config(input logic [BYTE_W-1:0] rtx, input logic [BYTE_W-1:0] ack,
                              input logic [BYTE_W-1:0] pad);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_RTX_CODE;
    cfg_wdata <= rtx;
    @(posedge clk);
    cfg_idx   <= CFG_ACK_CODE;
    cfg_wdata <= ack;
    @(posedge clk);
    cfg_idx   <= CFG_PAD_BYTE;
    cfg_wdata <= pad;
    @(posedge clk);
    cfg_we    <= 1'b0;
    rtx_now = rtx;
    ack_now = ack;
    pad_now = pad;
  endtask

  function automatic frame_kind_t pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return FR_DATA;
    if (r < 55) return FR_RESEND;
    if (r < 70) return FR_ACK;
    if (r < 82) return FR_NEAR_CONTROL;
    if (r < 92) return FR_BAD_CRC;
    return FR_NOISE;
  endfunction

  task automatic send_kind(input frame_kind_t kind);
    logic [BYTE_W-1:0] len;
    int unsigned       spot;
    case (kind)
      FR_DATA: begin
        fill_random();
        send_frame(8'($urandom), '0);
      end
      FR_RESEND: begin
        fill_control(rtx_now);
        send_frame(8'd1, '0);
      end
      FR_ACK: begin
        fill_control(ack_now);
        send_frame(8'd1, '0);
      end
      FR_NEAR_CONTROL: begin
        // A control frame with exactly one thing wrong: either the length
        // or a single payload byte. It should come out as a data frame.
        fill_control($urandom_range(0, 1) ? rtx_now : ack_now);
        len  = 8'd1;
        spot = $urandom_range(0, PL);
        if (spot == PL) len = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(2, 255));
        else frame_pl[spot] ^= 8'($urandom_range(1, 255));
        send_frame(len, '0);
      end
      FR_BAD_CRC: begin
        if ($urandom_range(0, 1)) fill_control(rtx_now);
        else fill_random();
        send_frame($urandom_range(0, 1) ? 8'd1 : 8'($urandom), 32'd1 << $urandom_range(0, 31));
      end
      default: begin
        // Raw noise, one whole frame long so that framing stays aligned.
        for (int i = 0; i < FRAME_BYTES; i++) send_byte(8'($urandom));
      end
    endcase
  endtask

  // Result side: a random stall before every request, and one long hold-off
  // whenever the stimulus asks for it, counted here.
  initial begin : result_sink
    int unsigned stall;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = draw_gap(out_no_idle);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Hang detector: any cycle that accepts a request on either channel
  // resets the count.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("** crc_checked_frame_receiver: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic [BYTE_W-1:0] code;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_RTX_CODE;
    cfg_wdata     = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames under the reset register values. The first one has
    // the largest length and payload bytes at both extremes.
    for (int i = 0; i < PL; i++) frame_pl[i] = i[0] ? 8'hFF : 8'h00;
    send_frame(8'hFF, '0);
    // Resend and ack control frames.
    fill_control(rtx_now);
    send_frame(8'd1, '0);
    fill_control(ack_now);
    send_frame(8'd1, '0);
    // Ack pattern with the last pad byte wrong, and a retransmit pattern
    // with length zero: both are plain data.
    fill_control(ack_now);
    frame_pl[PL-1] = ~pad_now;
    send_frame(8'd1, '0);
    fill_control(rtx_now);
    send_frame(8'd0, '0);
    // A bad CRC takes priority over a valid control pattern.
    fill_control(rtx_now);
    send_frame(8'd1, 32'h8000_0000);
    // The sender waits here until every result has come back.
    drain_results();

    // Random phases, each under its own register setting.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: write_config(8'h00, 8'hFF, 8'h00);
        1: begin
          // Equal codes: a matching frame must be taken as a retransmit.
          code = 8'($urandom);
          write_config(code, code, 8'($urandom));
        end
        2: write_config(8'($urandom), 8'($urandom), 8'($urandom));
        default: write_config(8'hFF, 8'h00, 8'hFF);
      endcase
      in_no_idle  = ($urandom_range(0, 2) == 0);
      out_no_idle = ($urandom_range(0, 2) == 0);
      if (p == 0) begin
        // Hold the result side off while the sender keeps offering data
        // frames back to back, so the block backs up to its input.
        in_no_idle = 1'b1;
        holds_asked++;
      end
      for (int f = 0; f < FRAMES_PER_PH; f++) begin
        if (p == 0 && f < 2) send_kind(FR_DATA);
        else send_kind(pick_kind());
      end
      drain_results();
    end

    if (mismatch_count == 0) begin
      $display("** crc_checked_frame_receiver: PASSED **");
    end else begin
      $display("** crc_checked_frame_receiver: FAILED **");
    end
    $finish;
  end

endmodule : tb_crc_checked_frame_receiver
